// File: src/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and letter helpers for the Playfair cipher block.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // Square geometry and letter codes (A=0 .. Z=25)
  localparam int unsigned SqDim   = 5;
  localparam int unsigned SqCells = SqDim * SqDim;
  localparam int unsigned NumLetters = 26;
  localparam logic [4:0]  CodeI   = 5'd8;
  localparam logic [4:0]  CodeJ   = 5'd9;
  localparam logic [4:0]  CodeX   = 5'd23;
  localparam logic [4:0]  CodeZ   = 5'd25;
  localparam logic [4:0]  CodeLast = 5'd25;
  localparam logic [7:0]  CharUpA = 8'h41;
  localparam logic [7:0]  CharUpZ = 8'h5A;
  localparam logic [7:0]  CharLoA = 8'h61;
  localparam logic [7:0]  CharLoZ = 8'h7A;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_KEY      = 2'd0,
    REQ_KEY_DONE = 2'd1,
    REQ_TEXT     = 2'd2,
    REQ_END      = 2'd3
  } req_e;

  // Register index on the config port
  localparam logic RegDecryptMode = 1'b0;

  // Decoded character
  typedef struct packed {
    logic       valid;
    logic [4:0] code;
  } lcode_t;

  // Control from the sequencer to the square storage
  typedef struct packed {
    logic       clear;
    logic       place_en;
    logic [4:0] place_code;
    logic       pos_rd_en;
    logic [4:0] pos_rd_addr;
    logic       sq_rd_en;
    logic [4:0] sq_rd_addr;
  } sq_ctrl_t;

  // Read data back from the square storage
  typedef struct packed {
    logic [4:0] pos_rdata;
    logic [4:0] sq_rdata;
  } sq_rsp_t;

  // Letter code with J folded to I; invalid for non-letters
  function automatic lcode_t letter_code(logic [7:0] ch);
    lcode_t r;
    r.valid = 1'b0;
    r.code  = '0;
    if (ch >= CharUpA && ch <= CharUpZ) begin
      r.valid = 1'b1;
      r.code  = 5'(ch - CharUpA);
    end else if (ch >= CharLoA && ch <= CharLoZ) begin
      r.valid = 1'b1;
      r.code  = 5'(ch - CharLoA);
    end
    if (r.code == CodeJ) begin
      r.code = CodeI;
    end
    return r;
  endfunction

  // Row of a square index (index / 5)
  function automatic logic [2:0] pos_row(logic [4:0] p);
    logic [2:0] r;
    if (p < 5'd5) begin
      r = 3'd0;
    end else if (p < 5'd10) begin
      r = 3'd1;
    end else if (p < 5'd15) begin
      r = 3'd2;
    end else if (p < 5'd20) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  // Row start index (row * 5)
  function automatic logic [4:0] row_base(logic [2:0] r);
    return 5'({r, 2'b00}) + 5'(r);
  endfunction

  // Column of a square index (index % 5)
  function automatic logic [2:0] pos_col(logic [4:0] p);
    logic [4:0] diff;
    diff = p - row_base(pos_row(p));
    return diff[2:0];
  endfunction

  // Step one place along a row or column: +1 to encrypt, +4 (i.e. -1) to decrypt
  function automatic logic [2:0] step5(logic [2:0] v, logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/pfc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready stream interfaces for the cipher request and result channels.
// ----------------------------------------------------------------------------

// Request channel: key/text characters and markers
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_in;

  modport source (output valid, output req_type, output char_in, input ready);
  modport sink   (input valid, input req_type, input char_in, output ready);
endinterface

// Result channel: ciphered letters and end markers
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last;

  modport source (output valid, output out_char, output char_valid, output last,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid, input last,
                  output ready);
endinterface
`default_nettype wire

// File: src/playfair_digraph_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher: builds a 5x5 key square from key characters, then ciphers
// text characters in pairs (in encrypt mode X goes between doubled letters and
// Z pads an odd tail).
// Usage: requests arrive on in_i (req_type, char_in), one beat at a time;
// results leave on out_o (out_char, char_valid, last). decrypt_mode is an APB
// register at byte address 0, to be written by the user only while the block
// is idle; the block itself does not enforce this.
// A key character, or a text character that completes no pair, gives no result.
// Key done on an unbuilt square walks the alphabet in S_FILL and places every
// letter not yet used, skipping J. A text character or end that completes a
// pair reads both positions (S_POS_A, S_POS_B), maps them (S_MAP1, S_MAP2) and
// gives two result beats (S_EMIT1, S_EMIT2); an end with no pending letter, or
// any end in decrypt mode, gives one bare end-marker beat. Pairs are serialised
// by each square memory's single read port and the one shared mapping unit.
// Reset clears flags, pending letters and the mode; the square memories hold
// no reset value and are rebuilt by the next key. A result beat sits in an
// output register; when the receiver stalls the sequencer waits for that
// register to free up, and in_i.ready stays low until the last beat of the
// item has been loaded into it.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pfc_in_if.sink      in_i,
  pfc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_POS_A,
    S_POS_B,
    S_MAP1,
    S_MAP2,
    S_EMIT1,
    S_EMIT2,
    S_MARK
  } state_e;

  state_e     state_q;
  logic       mode_q;
  logic       sq_ready_q;
  logic [4:0] pend_q, prev_q;
  logic       pend_v_q, prev_v_q;
  logic [4:0] a_q, b_q;
  logic       last_q;
  logic [4:0] fillc_q;
  logic [4:0] pa_q, pb_q, l1_q;
  logic       out_v_q;
  logic [7:0] out_char_q;
  logic       out_cv_q, out_last_q;

  sq_ctrl_t   sq_ctrl;
  sq_rsp_t    sq_rsp;
  lcode_t     lc;
  req_e       req;
  logic       in_beat, slot_free, cfg_wr;
  logic [4:0] map_own, map_oth, map_pos;

  // Text-character pairing decision
  logic       txt_pair;
  logic [4:0] txt_a, txt_b, txt_pend;
  logic       txt_pend_v;

  assign req       = req_e'(in_i.req_type);
  assign lc        = letter_code(in_i.char_in);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_beat   = in_i.valid && in_i.ready;
  assign slot_free = !out_v_q || out_o.ready;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegDecryptMode);
  assign prdata = (paddr[2] == RegDecryptMode) ? {31'd0, mode_q} : 32'd0;

  always_comb begin
    logic dbl;
    dbl        = !mode_q && prev_v_q && (prev_q == lc.code);
    txt_pair   = 1'b0;
    txt_a      = pend_q;
    txt_b      = lc.code;
    txt_pend   = lc.code;
    txt_pend_v = 1'b1;
    if (dbl) begin
      txt_pair = 1'b1;
      if (pend_v_q) begin
        txt_b = CodeX;
      end else begin
        txt_a      = CodeX;
        txt_pend_v = 1'b0;
      end
    end else if (pend_v_q) begin
      txt_pair   = 1'b1;
      txt_pend_v = 1'b0;
    end
  end

  // Shared mapping unit: first letter, then second with operands swapped
  assign map_own = (state_q == S_MAP1) ? pa_q : pb_q;
  assign map_oth = (state_q == S_MAP1) ? sq_rsp.pos_rdata : pa_q;

  pfc_map u_map (
    .decrypt_i   (mode_q),
    .own_pos_i   (map_own),
    .other_pos_i (map_oth),
    .out_pos_o   (map_pos)
  );

  // Square storage control
  always_comb begin
    sq_ctrl             = '0;
    sq_ctrl.place_code  = lc.code;
    sq_ctrl.pos_rd_addr = a_q;
    sq_ctrl.sq_rd_addr  = map_pos;
    case (state_q)
      S_IDLE: begin
        if (in_beat && req == REQ_KEY) begin
          sq_ctrl.clear    = sq_ready_q;
          sq_ctrl.place_en = lc.valid;
        end
      end
      S_FILL: begin
        sq_ctrl.place_code = fillc_q;
        sq_ctrl.place_en   = (fillc_q != CodeJ);
      end
      S_POS_A: sq_ctrl.pos_rd_en = 1'b1;
      S_POS_B: begin
        sq_ctrl.pos_rd_en   = 1'b1;
        sq_ctrl.pos_rd_addr = b_q;
      end
      S_MAP1:  sq_ctrl.sq_rd_en = 1'b1;
      S_MAP2:  sq_ctrl.sq_rd_en = 1'b1;
      default: sq_ctrl.sq_rd_en = 1'b0;
    endcase
  end

  pfc_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .rsp_o  (sq_rsp)
  );

  // Sequencer, pair state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= 1'b0;
      sq_ready_q <= 1'b0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      prev_q     <= '0;
      prev_v_q   <= 1'b0;
      a_q        <= '0;
      b_q        <= '0;
      last_q     <= 1'b0;
      fillc_q    <= '0;
      pa_q       <= '0;
      pb_q       <= '0;
      l1_q       <= '0;
      out_v_q    <= 1'b0;
      out_char_q <= '0;
      out_cv_q   <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_q <= pwdata[0];
      end
      if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            case (req)
              REQ_KEY: begin
                if (sq_ready_q) begin
                  sq_ready_q <= 1'b0;
                  pend_q     <= '0;
                  pend_v_q   <= 1'b0;
                  prev_q     <= '0;
                  prev_v_q   <= 1'b0;
                end
              end
              REQ_KEY_DONE: begin
                if (!sq_ready_q) begin
                  fillc_q <= '0;
                  state_q <= S_FILL;
                end
              end
              REQ_TEXT: begin
                if (sq_ready_q && lc.valid) begin
                  pend_q   <= txt_pend_v ? txt_pend : 5'd0;
                  pend_v_q <= txt_pend_v;
                  if (!mode_q) begin
                    prev_q   <= lc.code;
                    prev_v_q <= 1'b1;
                  end
                  if (txt_pair) begin
                    a_q     <= txt_a;
                    b_q     <= txt_b;
                    last_q  <= 1'b0;
                    state_q <= S_POS_A;
                  end
                end
              end
              default: begin
                if (sq_ready_q) begin
                  if (!mode_q && pend_v_q) begin
                    a_q     <= pend_q;
                    b_q     <= CodeZ;
                    last_q  <= 1'b1;
                    state_q <= S_POS_A;
                  end else begin
                    state_q <= S_MARK;
                  end
                  pend_q   <= '0;
                  pend_v_q <= 1'b0;
                  prev_q   <= '0;
                  prev_v_q <= 1'b0;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          fillc_q <= fillc_q + 5'd1;
          if (fillc_q == CodeLast) begin
            sq_ready_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        S_POS_A: state_q <= S_POS_B;
        S_POS_B: begin
          pa_q    <= sq_rsp.pos_rdata;
          state_q <= S_MAP1;
        end
        S_MAP1: begin
          pb_q    <= sq_rsp.pos_rdata;
          state_q <= S_MAP2;
        end
        S_MAP2: begin
          l1_q    <= sq_rsp.sq_rdata;
          state_q <= S_EMIT1;
        end
        S_EMIT1: begin
          if (slot_free) begin
            out_v_q    <= 1'b1;
            out_char_q <= CharUpA + 8'(l1_q);
            out_cv_q   <= 1'b1;
            out_last_q <= 1'b0;
            state_q    <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            out_v_q    <= 1'b1;
            out_char_q <= CharUpA + 8'(sq_rsp.sq_rdata);
            out_cv_q   <= 1'b1;
            out_last_q <= last_q;
            state_q    <= S_IDLE;
          end
        end
        S_MARK: begin
          if (slot_free) begin
            out_v_q    <= 1'b1;
            out_char_q <= '0;
            out_cv_q   <= 1'b0;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.out_char   = out_char_q;
  assign out_o.char_valid = out_cv_q;
  assign out_o.last       = out_last_q;

  // Key done on an unbuilt square starts the alphabet fill
  a_fill_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && req == REQ_KEY_DONE && !sq_ready_q |=> state_q == S_FILL)
    else $error("key done did not start the fill");

  // The square is never marked ready while it is still being filled
  a_fill_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> !sq_ready_q)
    else $error("square ready during fill");

  // A bare end marker always closes the text
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_cv_q |-> out_last_q && out_char_q == 8'd0)
    else $error("bare marker without last");

  // Letter beats carry an uppercase letter
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_cv_q |-> out_char_q >= CharUpA && out_char_q <= CharUpZ)
    else $error("result letter out of range");

  // The second letter of a pair is loaded right after the first
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT1 && slot_free |=> state_q == S_EMIT2 && out_v_q)
    else $error("pair emission out of order");

endmodule
`default_nettype wire

// File: src/pfc_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_map
// Shared position-mapping unit: given a letter's square index and its partner's,
// returns the square index of the ciphered letter (row, column, rectangle rule).
// ----------------------------------------------------------------------------
module pfc_map
  import pfc_pkg::*;
(
  input  logic       decrypt_i,
  input  logic [4:0] own_pos_i,
  input  logic [4:0] other_pos_i,
  output logic [4:0] out_pos_o
);

  logic [2:0] own_r, own_c, oth_r, oth_c;
  logic [2:0] res_r, res_c;

  assign own_r = pos_row(own_pos_i);
  assign own_c = pos_col(own_pos_i);
  assign oth_r = pos_row(other_pos_i);
  assign oth_c = pos_col(other_pos_i);

  // Same row shifts the column, same column shifts the row, else swap columns
  always_comb begin
    if (own_r == oth_r) begin
      res_r = own_r;
      res_c = step5(own_c, decrypt_i);
    end else if (own_c == oth_c) begin
      res_r = step5(own_r, decrypt_i);
      res_c = own_c;
    end else begin
      res_r = own_r;
      res_c = oth_c;
    end
  end

  assign out_pos_o = row_base(res_r) + 5'(res_c);

endmodule
`default_nettype wire

// File: src/pfc_square.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_square
// Key square storage: square and letter-position memories, used-letter flags
// and fill index. Places letters and serves one registered read per memory.
// ----------------------------------------------------------------------------
module pfc_square
  import pfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sq_ctrl_t ctrl_i,
  output sq_rsp_t  rsp_o
);

  logic [4:0]            key_sq_mem [SqCells];
  logic [4:0]            pos_mem    [NumLetters];
  logic [NumLetters-1:0] used_q;
  logic [4:0]            fill_q;
  logic [NumLetters-1:0] used_eff;
  logic [4:0]            fill_eff;
  logic                  do_place;
  logic [4:0]            pos_rdata_q;
  logic [4:0]            sq_rdata_q;

  // A new key clears flags and index in the same cycle as its first letter
  assign used_eff = ctrl_i.clear ? '0 : used_q;
  assign fill_eff = ctrl_i.clear ? '0 : fill_q;
  assign do_place = ctrl_i.place_en && !used_eff[ctrl_i.place_code]
                    && (fill_eff < 5'(SqCells));

  // Used flags and fill index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      fill_q <= '0;
    end else begin
      used_q <= used_eff | (do_place ? (NumLetters'(1) << ctrl_i.place_code) : '0);
      fill_q <= do_place ? fill_eff + 5'd1 : fill_eff;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      key_sq_mem[fill_eff]         <= ctrl_i.place_code;
      pos_mem[ctrl_i.place_code]   <= fill_eff;
    end
  end

  // Registered reads, held while not enabled
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pos_rd_en) begin
      pos_rdata_q <= pos_mem[ctrl_i.pos_rd_addr];
    end
    if (ctrl_i.sq_rd_en) begin
      sq_rdata_q <= key_sq_mem[ctrl_i.sq_rd_addr];
    end
  end

  assign rsp_o.pos_rdata = pos_rdata_q;
  assign rsp_o.sq_rdata  = sq_rdata_q;

endmodule
`default_nettype wire

// File: verif/playfair_digraph_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_tb
// Self-checking bench for the Playfair cipher block. Key and text beats are
// sent on the request stream. A cipher model inside the bench keeps its own
// key square, pair buffer and mode, and queues the letters that each beat
// should produce. Every result beat is checked field by field against the
// oldest queued letter. Both stream sides idle at random, with steady
// stretches, a long output hold-off and sender pauses. The mode register is
// written over APB only while the block is idle.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
  import pfc_pkg::*;

  // One result beat as the block should present it
  typedef struct packed {
    logic [7:0] letter;
    logic       is_letter;
    logic       tail;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  playfair_digraph_cipher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Cipher model state
  bit          dec_mode;
  logic [4:0]  letter_at [SqCells];
  logic [4:0]  slot_of [NumLetters];
  logic [25:0] placed;
  int unsigned filled;
  bit          square_ready;
  bit          pend_v;
  logic [4:0]  pend;
  bit          prev_v;
  logic [4:0]  prev;

  out_beat_t   expected_letters [$];
  int          mismatches;
  int          items_taken;
  bit          steady;
  int          sink_hold;

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Letter code 0..25 with J folded onto I, -1 for anything else
  function automatic int letter_index(logic [7:0] ch);
    int code;
    if (ch >= CharUpA && ch <= CharUpZ) begin
      code = int'(ch - CharUpA);
    end else if (ch >= CharLoA && ch <= CharLoZ) begin
      code = int'(ch - CharLoA);
    end else begin
      code = -1;
    end
    if (code == int'(CodeJ)) begin
      code = int'(CodeI);
    end
    return code;
  endfunction

  function automatic void place_in_square(logic [4:0] code);
    if (!placed[code] && filled < SqCells) begin
      letter_at[filled] = code;
      slot_of[code]     = 5'(filled);
      placed[code]      = 1'b1;
      filled++;
    end
  endfunction

  function automatic void expect_beat(logic [7:0] letter, logic is_letter, logic tail);
    out_beat_t b;
    b.letter    = letter;
    b.is_letter = is_letter;
    b.tail      = tail;
    expected_letters.push_back(b);
  endfunction

  // Same row / same column / rectangle rules on one digraph
  function automatic void encode_pair(logic [4:0] a, logic [4:0] b, logic tail);
    int unsigned pa, pb, r1, c1, r2, c2, sh, o1, o2;
    pa = slot_of[a];
    pb = slot_of[b];
    r1 = pa / SqDim;
    c1 = pa % SqDim;
    r2 = pb / SqDim;
    c2 = pb % SqDim;
    sh = dec_mode ? SqDim - 1 : 1;
    if (r1 == r2) begin
      o1 = r1 * SqDim + (c1 + sh) % SqDim;
      o2 = r2 * SqDim + (c2 + sh) % SqDim;
    end else if (c1 == c2) begin
      o1 = ((r1 + sh) % SqDim) * SqDim + c1;
      o2 = ((r2 + sh) % SqDim) * SqDim + c2;
    end else begin
      o1 = r1 * SqDim + c2;
      o2 = r2 * SqDim + c1;
    end
    expect_beat(CharUpA + 8'(letter_at[o1]), 1'b1, 1'b0);
    expect_beat(CharUpA + 8'(letter_at[o2]), 1'b1, tail);
  endfunction

  // Pair buffer: hold one letter, cipher on the second
  function automatic void push_letter(logic [4:0] code, logic tail);
    if (pend_v) begin
      encode_pair(pend, code, tail);
      pend_v = 1'b0;
      pend   = '0;
    end else begin
      pend   = code;
      pend_v = 1'b1;
    end
  endfunction

  function automatic void clear_text();
    pend_v = 1'b0;
    pend   = '0;
    prev_v = 1'b0;
    prev   = '0;
  endfunction

  // Apply one accepted request; returns 0 when the block just ignores it
  function automatic bit playfair_predict(req_e req, logic [7:0] ch);
    int code;
    bit took;
    code = letter_index(ch);
    took = 1'b0;
    case (req)
      REQ_KEY: begin
        took = square_ready || code >= 0;
        if (square_ready) begin
          placed       = '0;
          filled       = 0;
          square_ready = 1'b0;
          clear_text();
        end
        if (code >= 0) begin
          place_in_square(5'(code));
        end
      end
      REQ_KEY_DONE: begin
        took = !square_ready;
        if (!square_ready) begin
          for (int c = 0; c < NumLetters; c++) begin
            if (c != int'(CodeJ)) begin
              place_in_square(5'(c));
            end
          end
          square_ready = 1'b1;
        end
      end
      REQ_TEXT: begin
        if (square_ready && code >= 0) begin
          took = 1'b1;
          if (dec_mode) begin
            push_letter(5'(code), 1'b0);
          end else begin
            // X splits doubled letters, regardless of pair boundaries
            if (prev_v && prev == 5'(code)) begin
              push_letter(CodeX, 1'b0);
            end
            push_letter(5'(code), 1'b0);
            prev   = 5'(code);
            prev_v = 1'b1;
          end
        end
      end
      default: begin
        if (square_ready) begin
          took = 1'b1;
          if (!dec_mode && pend_v) begin
            push_letter(CodeZ, 1'b1);
          end else begin
            expect_beat(8'h00, 1'b0, 1'b1);
          end
          clear_text();
        end
      end
    endcase
    return took;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CharUpA + 8'($urandom_range(0, 25));
    if (r < 85) return CharLoA + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report(input string field, input int got, input int want);
    $display("%0t ERROR %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // One request beat; valid stays high when the next beat follows at once
  task automatic send_beat(input req_e req, input logic [7:0] ch);
    int gap;
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.char_in  <= ch;
    do @(posedge clk_i); while (!in_if.ready);
    void'(playfair_predict(req, ch));
    items_taken++;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(REQ_TEXT, s[i]);
    end
  endtask

  // Stop sending, wait for all letters, then let an in-flight key fill finish
  task automatic wait_idle(input int settle);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // APB write of the mode register, then read it back
  task automatic write_mode(input bit dec);
    wait_idle(40);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegDecryptMode, 2'b00};
    pwdata  <= 32'(dec);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dec_mode = dec;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(dec)) report("prdata", prdata, 32'(dec));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Text and end of text before any key are dropped
  task automatic test_text_before_key();
    send_beat(REQ_TEXT, "A");
    send_beat(REQ_END, 8'h00);
  endtask

  // Key with non-letters, lower case, J as I, repeats; key-done twice
  task automatic test_key_build();
    send_beat(REQ_KEY, 8'h00);
    send_beat(REQ_KEY, "P");
    send_beat(REQ_KEY, "l");
    send_beat(REQ_KEY, "a");
    send_beat(REQ_KEY, "y");
    send_beat(REQ_KEY, "f");
    send_beat(REQ_KEY, "J");
    send_beat(REQ_KEY, "i");
    send_beat(REQ_KEY, "r");
    send_beat(REQ_KEY_DONE, 8'h00);
    send_beat(REQ_KEY_DONE, 8'hFF);
  endtask

  // Doubled letters, J/I double, dropped byte, Z pad on Z, bare end marker
  task automatic test_encrypt_rules();
    send_beat(REQ_TEXT, "B");
    send_beat(REQ_TEXT, "b");
    send_beat(REQ_TEXT, 8'hFF);
    send_beat(REQ_TEXT, "J");
    send_beat(REQ_TEXT, "i");
    send_beat(REQ_TEXT, "Z");
    send_beat(REQ_END, 8'h00);
    send_beat(REQ_END, 8'hFF);
  endtask

  // Decrypt drops an odd last letter and ends with a bare marker
  task automatic test_decrypt_tail();
    write_mode(1'b1);
    send_text("Abc");
    send_beat(REQ_END, 8'h00);
    write_mode(1'b0);
  endtask

  // No gaps on either side
  task automatic test_full_rate();
    steady = 1'b1;
    send_text("TheQuickBrownFoxJumpsOverLazyDoggs");
    send_beat(REQ_END, 8'h00);
    wait_idle(0);
    steady = 1'b0;
  endtask

  // Receiver holds off while text keeps coming, so the input backs up
  task automatic test_output_backpressure();
    sink_hold = 300;
    for (int i = 0; i < 24; i++) begin
      send_beat(REQ_TEXT, CharUpA + 8'($urandom_range(0, 25)));
    end
    send_beat(REQ_END, 8'h00);
  endtask

  // Sender waits for every letter with one letter still pending
  task automatic test_sender_pause();
    send_beat(REQ_TEXT, "Q");
    wait_idle(0);
    send_beat(REQ_TEXT, "R");
    send_beat(REQ_END, 8'h00);
  endtask

  // Random keys and texts in both modes, with some noise and broken texts
  task automatic test_random_sessions();
    int nkey, ntext;
    logic [7:0] ch, last_ch;
    while (items_taken < 1450) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      nkey = $urandom_range(0, 12);
      for (int i = 0; i < nkey; i++) begin
        send_beat(REQ_KEY, rand_char());
      end
      if ($urandom_range(0, 9) == 0) send_beat(req_e'($urandom_range(2, 3)), rand_char());
      send_beat(REQ_KEY_DONE, rand_char());
      if ($urandom_range(0, 9) == 0) send_beat(REQ_KEY_DONE, rand_char());
      ntext   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      last_ch = rand_char();
      for (int i = 0; i < ntext; i++) begin
        // repeat the last byte now and then, sometimes with flipped case
        if ($urandom_range(0, 5) == 0) begin
          ch = last_ch ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end else begin
          ch = rand_char();
        end
        send_beat(REQ_TEXT, ch);
        last_ch = ch;
        if ($urandom_range(0, 39) == 0) wait_idle(0);
      end
      // some texts are cut short by the next key
      if ($urandom_range(0, 9) != 0) send_beat(REQ_END, rand_char());
    end
  endtask

  // Result side ready, with random stalls and requested long holds
  initial begin : sink_side
    int stall, held;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = 0;
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else if (!steady) begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < stall; held++) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Check each result beat against the oldest queued letter
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_letters.size() == 0) begin
        report("beat with nothing queued, out_char", out_if.out_char, 0);
      end else begin
        want = expected_letters.pop_front();
        if (out_if.out_char !== want.letter) report("out_char", out_if.out_char, want.letter);
        if (out_if.char_valid !== want.is_letter) begin
          report("char_valid", out_if.char_valid, want.is_letter);
        end
        if (out_if.last !== want.tail) report("last", out_if.last, want.tail);
      end
    end
  end

  // Run-time limit
  initial begin
    #20_000_000;
    $display("playfair_digraph_cipher: mismatch");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= REQ_KEY;
    in_if.char_in  <= 8'h00;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    dec_mode       = 1'b0;
    placed         = '0;
    filled         = 0;
    square_ready   = 1'b0;
    clear_text();
    mismatches     = 0;
    items_taken    = 0;
    steady         = 1'b0;
    sink_hold      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_before_key();
    test_key_build();
    test_encrypt_rules();
    test_decrypt_tail();
    test_full_rate();
    test_output_backpressure();
    test_sender_pause();
    test_random_sessions();

    wait_idle(40);
    if (mismatches == 0) begin
      $display("playfair_digraph_cipher: match");
    end else begin
      $display("playfair_digraph_cipher: mismatch");
    end
    $finish;
  end

endmodule
